/* sv/mau_pkg.sv */
// ============================================================================
// mau_pkg: modular arithmetic unit shared definitions
// Widths, operation codes and state encoding for the modular ALU.
// ============================================================================
package mau_pkg;

	localparam int DATA_WIDTH = 31;
	localparam int EXP_WIDTH  = 32;
	localparam int FUNC_W     = 3;
	localparam int ADDR_W     = 3;
	localparam int APB_DW     = 32;

	// exponent register holds either the item exponent or modulus minus two
	localparam int E_W   = (EXP_WIDTH > DATA_WIDTH) ? EXP_WIDTH : DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	localparam logic [DATA_WIDTH-1:0] MOD_RESET = DATA_WIDTH'(1000000007);
	localparam logic [DATA_WIDTH-1:0] ONE       = DATA_WIDTH'(1);
	localparam logic [DATA_WIDTH-1:0] TWO       = DATA_WIDTH'(2);

	localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
	localparam logic [FUNC_W-1:0] FN_POW = 3'd4;
	localparam logic [FUNC_W-1:0] FN_INV = 3'd5;
	localparam logic [FUNC_W-1:0] FN_NEG = 3'd6;

	localparam logic [0:0] REG_MODULUS = 1'b0;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_RED_A    = 12'b0000_0000_0010,
		S_RED_B    = 12'b0000_0000_0100,
		S_DISPATCH = 12'b0000_0000_1000,
		S_NEGB     = 12'b0000_0001_0000,
		S_ALU      = 12'b0000_0010_0000,
		S_MUL      = 12'b0000_0100_0000,
		S_POW_CHK  = 12'b0000_1000_0000,
		S_POW_MUL  = 12'b0001_0000_0000,
		S_POW_SQ   = 12'b0010_0000_0000,
		S_DIV_MUL  = 12'b0100_0000_0000,
		S_DONE     = 12'b1000_0000_0000
	} state_t;

endpackage

/* sv/mau_mulmod.sv */
// ============================================================================
// mau_mulmod: bit-serial modular multiplier
// Computes x*y mod m one bit of x per cycle, most significant bit first.
// y must be below m; x may take any value.
// ============================================================================
module mau_mulmod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mau_pkg::DATA_WIDTH-1:0] x,
	input  logic [mau_pkg::DATA_WIDTH-1:0] y,
	input  logic [mau_pkg::DATA_WIDTH-1:0] modulus,
	output logic                           done,
	output logic [mau_pkg::DATA_WIDTH-1:0] product
);
	import mau_pkg::*;

	localparam int TW = DATA_WIDTH + 2;

	logic [DATA_WIDTH-1:0] x_q, y_q, r_q, r_nx;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [TW-1:0]         t, m1, m2;

	always_comb begin
		m1   = {2'b00, modulus};
		m2   = {1'b0, modulus, 1'b0};
		t    = {1'b0, r_q, 1'b0} + (x_q[DATA_WIDTH-1] ? {2'b00, y_q} : '0);
		if (t >= m2) begin
			r_nx = DATA_WIDTH'(t - m2);
		end else if (t >= m1) begin
			r_nx = DATA_WIDTH'(t - m1);
		end else begin
			r_nx = DATA_WIDTH'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(DATA_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
			r_q <= r_nx;
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

/* sv/modular_arithmetic_unit_top.sv */
// ============================================================================
// modular_arithmetic_unit_top: modular ALU with Fermat inverse
// One operation modulo a programmable modulus per item, on one shared
// bit-serial modular multiplier.
// ============================================================================
// The unit takes no new item while an item is in progress. Every modular
// multiply runs on the bit-serial multiplier, and both operands are first
// reduced by that unit. Power runs square-and-multiply over the exponent,
// one multiply per set bit and one square per bit below the top set bit;
// inverse and divide raise to modulus minus two. A new item is accepted
// while the last result still waits in the output register.
module modular_arithmetic_unit_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mau_pkg::ADDR_W-1:0]     paddr,
	input  logic [mau_pkg::APB_DW-1:0]     pwdata,
	output logic [mau_pkg::APB_DW-1:0]     prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [mau_pkg::FUNC_W-1:0]     func,
	input  logic [mau_pkg::DATA_WIDTH-1:0] operand_a,
	input  logic [mau_pkg::DATA_WIDTH-1:0] operand_b,
	input  logic [mau_pkg::EXP_WIDTH-1:0]  exponent,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [mau_pkg::DATA_WIDTH-1:0] result
);
	import mau_pkg::*;

	state_t                state_q;
	logic [DATA_WIDTH-1:0] mod_q;
	logic [FUNC_W-1:0]     func_q;
	logic [DATA_WIDTH-1:0] ra_q, rb_q, acc_q, sq_q, result_q;
	logic [E_W-1:0]        e_q;
	logic                  mul_pend_q, result_valid_q;

	logic                  mul_start, mul_done;
	logic [DATA_WIDTH-1:0] mul_x, mul_y, mul_p;
	logic [DATA_WIDTH:0]   sum;
	logic [DATA_WIDTH-1:0] alu_res;
	logic                  cfg_wr, item_acc, out_load, sq_needed;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MODULUS);
	assign prdata   = (paddr[ADDR_W-1] == REG_MODULUS) ? APB_DW'(mod_q) : '0;
	assign item_ready = (state_q == S_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign out_load   = (state_q == S_DONE) && (!result_valid_q || result_ready);
	assign sq_needed  = (e_q[E_W-1:1] != '0);

	always_comb begin
		sum     = {1'b0, ra_q} + {1'b0, rb_q};
		alu_res = (sum >= {1'b0, mod_q}) ? DATA_WIDTH'(sum - {1'b0, mod_q})
		                                 : DATA_WIDTH'(sum);
	end

	always_comb begin
		mul_x     = ra_q;
		mul_y     = rb_q;
		mul_start = 1'b0;
		case (state_q)
			S_RED_A: begin
				mul_x     = ra_q;
				mul_y     = ONE;
				mul_start = !mul_pend_q;
			end
			S_RED_B: begin
				mul_x     = rb_q;
				mul_y     = ONE;
				mul_start = !mul_pend_q;
			end
			S_MUL: begin
				mul_start = !mul_pend_q;
			end
			S_POW_MUL: begin
				mul_x     = acc_q;
				mul_y     = sq_q;
				mul_start = !mul_pend_q;
			end
			S_POW_SQ: begin
				mul_x     = sq_q;
				mul_y     = sq_q;
				mul_start = !mul_pend_q && sq_needed;
			end
			S_DIV_MUL: begin
				mul_x     = ra_q;
				mul_y     = acc_q;
				mul_start = !mul_pend_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mau_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.y       (mul_y),
		.modulus (mod_q),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mod_q          <= MOD_RESET;
			mul_pend_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mod_q <= pwdata[DATA_WIDTH-1:0];
			end
			if (mul_start) begin
				mul_pend_q <= 1'b1;
			end else if (mul_done) begin
				mul_pend_q <= 1'b0;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						state_q <= (mod_q < TWO) ? S_DONE : S_RED_A;
					end
				end
				S_RED_A: begin
					if (mul_pend_q && mul_done) begin
						state_q <= S_RED_B;
					end
				end
				S_RED_B: begin
					if (mul_pend_q && mul_done) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (func_q)
						FN_ADD:                 state_q <= S_ALU;
						FN_SUB, FN_NEG:         state_q <= S_NEGB;
						FN_MUL:                 state_q <= S_MUL;
						FN_DIV, FN_POW, FN_INV: state_q <= S_POW_CHK;
						default:                state_q <= S_DONE;
					endcase
				end
				S_NEGB: begin
					state_q <= S_ALU;
				end
				S_ALU: begin
					state_q <= S_DONE;
				end
				S_MUL: begin
					if (mul_pend_q && mul_done) begin
						state_q <= S_DONE;
					end
				end
				S_POW_CHK: begin
					if (e_q == '0) begin
						state_q <= (func_q == FN_DIV) ? S_DIV_MUL : S_DONE;
					end else if (e_q[0]) begin
						state_q <= S_POW_MUL;
					end else begin
						state_q <= S_POW_SQ;
					end
				end
				S_POW_MUL: begin
					if (mul_pend_q && mul_done) begin
						state_q <= S_POW_SQ;
					end
				end
				S_POW_SQ: begin
					if (!sq_needed && !mul_pend_q) begin
						state_q <= S_POW_CHK;
					end else if (mul_pend_q && mul_done) begin
						state_q <= S_POW_CHK;
					end
				end
				S_DIV_MUL: begin
					if (mul_pend_q && mul_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= acc_q;
		end
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					func_q <= func;
					ra_q   <= operand_a;
					rb_q   <= operand_b;
					e_q    <= E_W'(exponent);
					acc_q  <= '0;
				end
			end
			S_RED_A: begin
				if (mul_pend_q && mul_done) begin
					ra_q <= mul_p;
				end
			end
			S_RED_B: begin
				if (mul_pend_q && mul_done) begin
					rb_q <= mul_p;
				end
			end
			S_DISPATCH: begin
				acc_q <= ONE;
				case (func_q)
					FN_POW: begin
						sq_q <= ra_q;
					end
					FN_INV: begin
						sq_q <= ra_q;
						e_q  <= E_W'(mod_q - TWO);
					end
					FN_DIV: begin
						sq_q <= rb_q;
						e_q  <= E_W'(mod_q - TWO);
					end
					FN_ADD, FN_SUB, FN_MUL, FN_NEG: begin
						sq_q <= ra_q;
					end
					default: begin
						acc_q <= '0;
					end
				endcase
			end
			S_NEGB: begin
				rb_q <= mod_q - ((func_q == FN_NEG) ? ra_q : rb_q);
				if (func_q == FN_NEG) begin
					ra_q <= '0;
				end
			end
			S_ALU: begin
				acc_q <= alu_res;
			end
			S_MUL, S_DIV_MUL: begin
				if (mul_pend_q && mul_done) begin
					acc_q <= mul_p;
				end
			end
			S_POW_MUL: begin
				if (mul_pend_q && mul_done) begin
					acc_q  <= mul_p;
					e_q[0] <= 1'b0;
				end
			end
			S_POW_SQ: begin
				if (!sq_needed && !mul_pend_q) begin
					e_q <= '0;
				end else if (mul_pend_q && mul_done) begin
					sq_q <= mul_p;
					e_q  <= e_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* sv/mau_checker.sv */
// ============================================================================
// mau_checker: port-level checks for the modular arithmetic unit
// Watches the item and result channels of the top level over time.
// ============================================================================
module mau_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [mau_pkg::DATA_WIDTH-1:0] result
);
	import mau_pkg::*;

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous item still in progress");

	// a new result only comes out of a busy unit
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without an item in progress");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result beat dropped or changed");

endmodule

bind modular_arithmetic_unit_top mau_checker u_mau_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking testbench for the modular arithmetic unit
// Programs the modulus over APB, sends operation beats on the item channel
// and compares every result beat against a behavioral model of the modular
// ALU. Directed cases cover the operand and modulus extremes, every func
// code and the degenerate moduli; random phases follow with a new modulus,
// sender burst gap limit and receiver ready mode in each phase.
// ============================================================================
module tb_top;
	import mau_pkg::*;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [EXP_WIDTH-1:0]  exp_t;
	typedef logic [FUNC_W-1:0]     func_t;

	typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_BURSTY, RDY_PATTERN} rdy_mode_t;

	localparam func_t             FN_UNUSED      = 3'd7;
	localparam logic [ADDR_W-1:0] ADDR_MODULUS   = ADDR_W'(4 * REG_MODULUS);
	localparam int                WATCHDOG_LIMIT = 20000;
	localparam int                TAIL_CYCLES    = 2400;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [APB_DW-1:0] pwdata       = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              item_valid   = 1'b0;
	logic              item_ready;
	func_t             func         = FN_ADD;
	data_t             operand_a    = '0;
	data_t             operand_b    = '0;
	exp_t              exponent     = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	data_t             result;

	data_t     modulus_cfg = MOD_RESET;
	data_t     expected_residues[$];
	int        fail_count  = 0;
	int        idle_cycles = 0;
	int        burst_left  = 0;
	int        gap_max     = 0;
	int        stall_left  = 0;
	int        rdy_tick    = 0;
	rdy_mode_t rdy_mode    = RDY_ALWAYS;

	modular_arithmetic_unit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (func),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.exponent     (exponent),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		return (x * y) % m;
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1 % m;
		sq  = base;
		while (e != 0) begin
			if (e[0])
				acc = mulmod(acc, sq, m);
			sq = mulmod(sq, sq, m);
			e  = e >> 1;
		end
		return acc;
	endfunction

	function automatic data_t modular_op(data_t m_in, func_t fn, data_t a_in, data_t b_in,
			exp_t e);
		logic [63:0] m;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		if (m_in < 2)
			return '0;
		m = 64'(m_in);
		a = 64'(a_in) % m;
		b = 64'(b_in) % m;
		case (fn)
			FN_ADD: r = a + b;
			FN_SUB: r = a + m - b;
			FN_MUL: r = mulmod(a, b, m);
			FN_DIV: r = mulmod(a, powmod(b, m - 2, m), m);
			FN_POW: r = powmod(a, 64'(e), m);
			FN_INV: r = powmod(a, m - 2, m);
			FN_NEG: r = m - a;
			default: r = 0;
		endcase
		if (r >= m)
			r = r - m;
		return data_t'(r);
	endfunction

	function automatic data_t rand_operand(data_t m);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (m < 2 || sel == 0)
			return data_t'($urandom);
		if (sel == 1)
			return '0;
		if (sel == 2)
			return m - data_t'(1);
		return data_t'($urandom % m);
	endfunction

	function automatic exp_t rand_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return exp_t'($urandom_range(1, 64));
			default: return exp_t'($urandom);
		endcase
	endfunction

	// result checker, expectation capture and watchdog
	always @(posedge clk) begin
		data_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_residues.size() == 0) begin
					$display("%0t unexpected result beat: expected none actual %0d",
						$time, result);
					fail_count++;
				end else begin
					want = expected_residues.pop_front();
					if (result !== want) begin
						$display("%0t result mismatch: expected %0d actual %0d",
							$time, want, result);
						fail_count++;
					end
				end
			end
			if (item_valid && item_ready)
				expected_residues.push_back(modular_op(modulus_cfg, func, operand_a,
					operand_b, exponent));
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// receiver stall patterns
	always @(posedge clk) begin
		rdy_tick++;
		case (rdy_mode)
			RDY_ALWAYS: result_ready <= 1'b1;
			RDY_RANDOM: result_ready <= ($urandom_range(0, 2) != 0);
			RDY_BURSTY: begin
				if (stall_left > 0) begin
					result_ready <= 1'b0;
					stall_left--;
				end else begin
					result_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(1, 40);
				end
			end
			default: result_ready <= ((rdy_tick % 7) < 4);
		endcase
	end

	task automatic send_op(input func_t fn, input data_t a, input data_t b, input exp_t e);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		func       <= fn;
		operand_a  <= a;
		operand_b  <= b;
		exponent   <= e;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_residues.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] value,
			output logic [APB_DW-1:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_MODULUS;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
	endtask

	task automatic check_modulus_reg();
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, '0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[DATA_WIDTH-1:0] !== modulus_cfg) begin
			$display("%0t modulus readback mismatch: expected %0d actual %0d",
				$time, modulus_cfg, rd[DATA_WIDTH-1:0]);
			fail_count++;
		end
	endtask

	task automatic set_modulus(input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, value, rd);
		modulus_cfg = value[DATA_WIDTH-1:0];
		check_modulus_reg();
	endtask

	task automatic test_directed_ops();
		data_t m1;
		check_modulus_reg();
		rdy_mode = RDY_ALWAYS;
		gap_max  = 0;
		m1 = modulus_cfg - data_t'(1);
		send_op(FN_ADD, '0, '0, '0);
		send_op(FN_ADD, m1, m1, '0);
		send_op(FN_SUB, '0, m1, '0);
		send_op(FN_SUB, m1, '0, '0);
		send_op(FN_MUL, m1, m1, '1);
		send_op(FN_MUL, '1, '1, '0);
		send_op(FN_DIV, 31'd12345, 31'd678, '0);
		send_op(FN_DIV, m1, '0, '0);
		send_op(FN_POW, 31'd2, '0, '0);
		send_op(FN_POW, m1, m1, '1);
		send_op(FN_POW, '0, '0, '0);
		send_op(FN_INV, '0, '0, '0);
		send_op(FN_INV, 31'd1, '0, '0);
		send_op(FN_INV, m1, '1, '0);
		send_op(FN_NEG, '0, '0, '0);
		send_op(FN_NEG, m1, '0, '0);
		send_op(FN_UNUSED, 31'd5, 31'd6, '1);
		send_op(FN_ADD, '1, modulus_cfg, '0);
		drain();
	endtask

	task automatic test_degenerate_moduli();
		set_modulus(32'd2);
		send_op(FN_INV, '0, '0, '0);
		send_op(FN_DIV, 31'd1, '0, '0);
		send_op(FN_POW, 31'd1, '0, '1);
		send_op(FN_NEG, 31'd1, '0, '0);
		drain();
		set_modulus(32'd1);
		send_op(FN_ADD, 31'd3, 31'd4, '0);
		send_op(FN_POW, 31'd5, '0, '0);
		drain();
		set_modulus(32'd0);
		send_op(FN_MUL, '1, '1, '0);
		send_op(FN_INV, 31'd7, '0, '0);
		drain();
	endtask

	task automatic test_random_phase(input logic [APB_DW-1:0] mod_word, input int count,
			input rdy_mode_t mode, input int gap_limit);
		func_t fn;
		set_modulus(mod_word);
		rdy_mode = mode;
		gap_max  = gap_limit;
		for (int i = 0; i < count; i++) begin
			fn = ($urandom_range(0, 19) == 0) ? FN_UNUSED : func_t'($urandom_range(0, 6));
			send_op(fn, rand_operand(modulus_cfg), rand_operand(modulus_cfg),
				rand_exponent());
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_degenerate_moduli();
		test_random_phase(32'd1000000007, 60, RDY_ALWAYS, 0);
		test_random_phase(32'hFFFF_FFFF, 45, RDY_RANDOM, 40);
		test_random_phase(32'd998244353, 40, RDY_BURSTY, 150);
		test_random_phase(32'($urandom_range(2, 32'h7FFF_FFFF)), 40, RDY_PATTERN, 20);
		test_random_phase(32'($urandom_range(2, 300)), 50, RDY_RANDOM, 10);
		test_random_phase(32'd65537, 30, RDY_BURSTY, 80);
		test_random_phase(32'd3, 12, RDY_PATTERN, 5);
		test_random_phase(32'd2, 12, RDY_RANDOM, 5);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_residues.size() != 0) begin
			$display("%0t results missing: expected %0d more actual 0",
				$time, expected_residues.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
